>>> rtl/ssk_pkg.sv
`timescale 1ns / 1ps

package ssk_pkg;

    // result field widths
    localparam int SKEW_W   = 23;
    localparam int MEAN_W   = 24;
    localparam int STATUS_W = 2;

    // skew magnitude is found one bit at a time, 23 bits
    localparam int ROOT_W    = 23;
    localparam int K_W       = ROOT_W + 1;
    localparam int BIT_W     = $clog2(ROOT_W);
    localparam int RHS_SHIFT = 34;
    localparam int MEAN_FRAC = 8;
    localparam int MIN_SAMPLES = 3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVF  = 2'd3;

    // multiplier operations
    typedef enum logic [2:0] {
        MOP_D2 = 3'd0,  // |d| * |d|
        MOP_D3 = 3'd1,  // d^2 * |d|
        MOP_R1 = 3'd2,  // S3 * S3
        MOP_R2 = 3'd3,  // S3^2 * n
        MOP_C1 = 3'd4,  // S2 * S2
        MOP_C2 = 3'd5,  // S2^2 * S2
        MOP_P1 = 3'd6,  // cube * k
        MOP_P2 = 3'd7   // cube * k * k
    } t_mop;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_go;
        logic dev;
        logic mul_go;
        logic mul_take;
        t_mop op;
        logic next_idx;
        logic init_root;
        logic next_bit;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic idx_last;
        logic bit_end;
        logic skip_root;
        logic out_free;
    } t_sts;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> rtl/ssk_ram.sv
`timescale 1ns / 1ps

module ssk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ssk_mul.sv
`timescale 1ns / 1ps

module ssk_mul #(
    parameter int A_W = 243,
    parameter int B_W = 92
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  logic [A_W-1:0] i_a,
    input  logic [B_W-1:0] i_b,
    output logic           o_busy,
    output logic           o_done,
    output logic [A_W-1:0] o_prod
);

    logic           r_busy;
    logic [A_W-1:0] r_acc;
    logic [A_W-1:0] r_a;
    logic [B_W-1:0] r_b;

    // busy until the multiplier bits run out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_go) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_b == '0)) begin
            r_busy <= 1'b0;
        end
    end

    // shift-add, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy && (r_b != '0)) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_busy && (r_b == '0);
    assign o_prod = r_acc;

endmodule

>>> rtl/ssk_ctrl.sv
`timescale 1ns / 1ps

module ssk_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_last,
    input  ssk_pkg::t_sts i_sts,
    output ssk_pkg::t_cmd o_cmd,
    output logic          o_stall
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_DIV_GO   = 10'b00_0000_0010,
        S_DIV_WAIT = 10'b00_0000_0100,
        S_P_RD     = 10'b00_0000_1000,
        S_P_DEV    = 10'b00_0001_0000,
        S_M_GO     = 10'b00_0010_0000,
        S_M_WAIT   = 10'b00_0100_0000,
        S_ROOT_CHK = 10'b00_1000_0000,
        S_FIN      = 10'b01_0000_0000,
        S_SPARE    = 10'b10_0000_0000
    } t_state;

    t_state        r_state, n_state;
    ssk_pkg::t_mop r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= ssk_pkg::MOP_D2;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // sequencing of load, mean division, deviation pass, root search and result hand-off
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        o_cmd.op = r_op;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall   = 1'b0;
                o_cmd.load = i_valid;
                if (i_valid && i_last) begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_P_RD;
                end
            end
            S_P_RD: begin
                n_state = S_P_DEV;
            end
            S_P_DEV: begin
                o_cmd.dev = 1'b1;
                n_op      = ssk_pkg::MOP_D2;
                n_state   = S_M_GO;
            end
            S_M_GO: begin
                o_cmd.mul_go = 1'b1;
                n_state      = S_M_WAIT;
            end
            S_M_WAIT: begin
                if (i_sts.mul_done) begin
                    o_cmd.mul_take = 1'b1;
                    n_state        = S_M_GO;
                    unique case (r_op)
                        ssk_pkg::MOP_D2: n_op = ssk_pkg::MOP_D3;
                        ssk_pkg::MOP_D3: begin
                            if (i_sts.idx_last) begin
                                n_state = S_ROOT_CHK;
                            end else begin
                                o_cmd.next_idx = 1'b1;
                                n_state        = S_P_RD;
                            end
                        end
                        ssk_pkg::MOP_R1: n_op = ssk_pkg::MOP_R2;
                        ssk_pkg::MOP_R2: n_op = ssk_pkg::MOP_C1;
                        ssk_pkg::MOP_C1: n_op = ssk_pkg::MOP_C2;
                        ssk_pkg::MOP_C2: n_op = ssk_pkg::MOP_P1;
                        ssk_pkg::MOP_P1: n_op = ssk_pkg::MOP_P2;
                        ssk_pkg::MOP_P2: begin
                            if (i_sts.bit_end) begin
                                n_state = S_FIN;
                            end else begin
                                o_cmd.next_bit = 1'b1;
                                n_op           = ssk_pkg::MOP_P1;
                            end
                        end
                        default: n_op = r_op;
                    endcase
                end
            end
            S_ROOT_CHK: begin
                if (i_sts.skip_root) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.init_root = 1'b1;
                    n_op            = ssk_pkg::MOP_R1;
                    n_state         = S_M_GO;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/ssk_dp.sv
`timescale 1ns / 1ps

module ssk_dp #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ssk_pkg::t_cmd                   i_cmd,
    output ssk_pkg::t_sts                   o_sts,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [ssk_pkg::SKEW_W-1:0]      o_skew_value,
    output logic [ssk_pkg::MEAN_W-1:0]      o_mean_value,
    output logic [ssk_pkg::STATUS_W-1:0]    o_status
);

    localparam int N_W   = $clog2(MAX_SAMPLES + 1);
    localparam int A_W   = $clog2(MAX_SAMPLES);
    localparam int SUM_W = N_W + SAMPLE_BITS;
    localparam int D_W   = SUM_W + 1;
    localparam int AD_W  = SUM_W;
    localparam int S2_W  = 2 * AD_W + N_W;
    localparam int S3_W  = 3 * AD_W + N_W;
    localparam int S3S_W = S3_W + 1;
    localparam int PW    = 2 * ssk_pkg::K_W + 3 * S2_W;
    localparam int MB    = ssk_pkg::max2(S3_W, ssk_pkg::K_W);
    localparam int NUM_W = SUM_W + ssk_pkg::MEAN_FRAC + 2;
    localparam int DEN_W = N_W + 1;
    localparam int DC_W  = $clog2(NUM_W + 1);
    localparam int QX_W  = ssk_pkg::max2(NUM_W, ssk_pkg::MEAN_W) + 1;
    localparam int RW    = ssk_pkg::ROOT_W;

    localparam logic [RW-1:0]    SKEW_CAP = {1'b1, {(RW - 1){1'b0}}};
    localparam logic [QX_W-1:0]  MEAN_POS = QX_W'((2 ** (ssk_pkg::MEAN_W - 1)) - 1);
    localparam logic [QX_W-1:0]  MEAN_NEG = QX_W'(2 ** (ssk_pkg::MEAN_W - 1));

    // list state
    logic                    count_ok;
    logic [N_W-1:0]          r_count;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_ovf;

    // deviation pass
    logic [N_W-1:0]          r_idx;
    logic                    r_dneg;
    logic [AD_W-1:0]         r_dmag;
    logic [2*AD_W-1:0]       r_d2;
    logic [S2_W-1:0]         r_s2;
    logic signed [S3S_W-1:0] r_s3;

    // root search
    logic [PW-1:0]           r_rhs;
    logic [PW-1:0]           r_cube;
    logic [PW-1:0]           r_prod;
    logic [RW-1:0]           r_root;
    logic [ssk_pkg::BIT_W-1:0] r_bit;

    // mean divider
    logic                    r_dbusy;
    logic [NUM_W-1:0]        r_q;
    logic [DEN_W-1:0]        r_rem;
    logic [DC_W-1:0]         r_dcnt;
    logic                    r_mneg;

    // output register
    logic                         r_out_valid;
    logic [ssk_pkg::SKEW_W-1:0]   r_o_skew;
    logic [ssk_pkg::MEAN_W-1:0]   r_o_mean;
    logic [ssk_pkg::STATUS_W-1:0] r_o_status;

    logic                    room;
    logic [SAMPLE_BITS-1:0]  ram_rdata;
    logic                    mul_busy, mul_done;
    logic [PW-1:0]           mul_a, mul_prod;
    logic [MB-1:0]           mul_b;
    logic signed [D_W-1:0]   nx, dev;
    logic [D_W-1:0]          dev_mag;
    logic [S3S_W-1:0]        s3_abs;
    logic [S3_W-1:0]         s3_mag;
    logic [S3S_W-1:0]        cube3;
    logic [RW-1:0]           trial;
    logic [ssk_pkg::K_W-1:0] k_odd;
    logic [SUM_W-1:0]        sum_abs;
    logic [DEN_W:0]          dstep;
    logic [DEN_W-1:0]        den;
    logic [QX_W-1:0]         qx;
    logic [QX_W-1:0]         qx_neg;
    logic [RW-1:0]           root_lo;
    logic                    skip;

    assign room = (r_count < N_W'(MAX_SAMPLES));

    ssk_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SAMPLES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && room),
        .i_waddr (r_count[A_W-1:0]),
        .i_wdata (i_sample),
        .i_raddr (r_idx[A_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // list loading and clearing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_count <= '0;
            r_sum   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.load) begin
            if (room) begin
                r_count <= r_count + N_W'(1);
                r_sum   <= r_sum + SUM_W'($signed(i_sample));
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end
    assign count_ok = (r_count >= N_W'(ssk_pkg::MIN_SAMPLES));

    // exact deviation d = n*x - S
    assign nx      = $signed({1'b0, r_count}) * $signed(ram_rdata);
    assign dev     = nx - D_W'(r_sum);
    assign dev_mag = dev[D_W-1] ? D_W'(-dev) : D_W'(dev);

    assign s3_abs = r_s3[S3S_W-1] ? S3S_W'(-r_s3) : S3S_W'(r_s3);
    assign s3_mag = s3_abs[S3_W-1:0];
    assign cube3  = S3S_W'(mul_prod[3*AD_W-1:0]);

    // trial value with the current bit set, k = 2t - 1
    assign trial = r_root | (RW'(1) << r_bit);
    assign k_odd = {trial, 1'b0} - ssk_pkg::K_W'(1);

    // multiplier operand select
    always_comb begin
        unique case (i_cmd.op)
            ssk_pkg::MOP_D2: begin mul_a = PW'(r_dmag); mul_b = MB'(r_dmag); end
            ssk_pkg::MOP_D3: begin mul_a = PW'(r_d2);   mul_b = MB'(r_dmag); end
            ssk_pkg::MOP_R1: begin mul_a = PW'(s3_mag); mul_b = MB'(s3_mag); end
            ssk_pkg::MOP_R2: begin mul_a = r_rhs;       mul_b = MB'(r_count); end
            ssk_pkg::MOP_C1: begin mul_a = PW'(r_s2);   mul_b = MB'(r_s2); end
            ssk_pkg::MOP_C2: begin mul_a = r_cube;      mul_b = MB'(r_s2); end
            ssk_pkg::MOP_P1: begin mul_a = r_cube;      mul_b = MB'(k_odd); end
            ssk_pkg::MOP_P2: begin mul_a = r_prod;      mul_b = MB'(k_odd); end
            default:         begin mul_a = '0;          mul_b = '0; end
        endcase
    end

    ssk_mul #(
        .A_W (PW),
        .B_W (MB)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // moment sums and root search registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_go) begin
            r_idx <= '0;
            r_s2  <= '0;
            r_s3  <= '0;
        end
        if (i_cmd.next_idx) begin
            r_idx <= r_idx + N_W'(1);
        end
        if (i_cmd.dev) begin
            r_dneg <= dev[D_W-1];
            r_dmag <= dev_mag[AD_W-1:0];
        end
        if (i_cmd.init_root) begin
            r_root <= '0;
            r_bit  <= ssk_pkg::BIT_W'(RW - 1);
        end
        if (i_cmd.next_bit) begin
            r_bit <= r_bit - ssk_pkg::BIT_W'(1);
        end
        if (i_cmd.mul_take) begin
            unique case (i_cmd.op)
                ssk_pkg::MOP_D2: begin
                    r_d2 <= mul_prod[2*AD_W-1:0];
                    r_s2 <= r_s2 + S2_W'(mul_prod[2*AD_W-1:0]);
                end
                ssk_pkg::MOP_D3: begin
                    if (r_dneg) begin
                        r_s3 <= r_s3 - $signed(cube3);
                    end else begin
                        r_s3 <= r_s3 + $signed(cube3);
                    end
                end
                ssk_pkg::MOP_R1: r_rhs  <= mul_prod;
                ssk_pkg::MOP_R2: r_rhs  <= mul_prod << ssk_pkg::RHS_SHIFT;
                ssk_pkg::MOP_C1: r_cube <= mul_prod;
                ssk_pkg::MOP_C2: r_cube <= mul_prod;
                ssk_pkg::MOP_P1: r_prod <= mul_prod;
                ssk_pkg::MOP_P2: begin
                    if (mul_prod <= r_rhs) begin
                        r_root <= trial;
                    end
                end
                default: r_prod <= r_prod;
            endcase
        end
    end

    // mean: (2*|256 S| + n) / (2n), restoring, one quotient bit per cycle
    assign sum_abs = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign den     = {r_count, 1'b0};
    assign dstep   = {r_rem, r_q[NUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
        end else if (i_cmd.div_go) begin
            r_dbusy <= 1'b1;
        end else if (r_dbusy && (r_dcnt == DC_W'(NUM_W - 1))) begin
            r_dbusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_go) begin
            r_q    <= (NUM_W'(sum_abs) << (ssk_pkg::MEAN_FRAC + 1)) + NUM_W'(r_count);
            r_rem  <= '0;
            r_dcnt <= '0;
            r_mneg <= r_sum[SUM_W-1];
        end else if (r_dbusy) begin
            r_dcnt <= r_dcnt + DC_W'(1);
            if (dstep >= {1'b0, den}) begin
                r_rem <= DEN_W'(dstep - {1'b0, den});
                r_q   <= {r_q[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= dstep[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign qx      = QX_W'(r_q);
    assign qx_neg  = ~qx + QX_W'(1);
    assign root_lo = (r_root > SKEW_CAP) ? SKEW_CAP : r_root;
    assign skip    = !count_ok || (r_s2 == '0);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (skip) begin
                r_o_skew <= '0;
            end else if (r_s3[S3S_W-1]) begin
                r_o_skew <= ssk_pkg::SKEW_W'(-root_lo);
            end else if (root_lo > SKEW_CAP - RW'(1)) begin
                r_o_skew <= ssk_pkg::SKEW_W'(SKEW_CAP - RW'(1));
            end else begin
                r_o_skew <= ssk_pkg::SKEW_W'(root_lo);
            end

            if (r_mneg) begin
                r_o_mean <= (qx > MEAN_NEG) ? ssk_pkg::MEAN_W'(MEAN_NEG)
                                            : qx_neg[ssk_pkg::MEAN_W-1:0];
            end else begin
                r_o_mean <= (qx > MEAN_POS) ? ssk_pkg::MEAN_W'(MEAN_POS)
                                            : qx[ssk_pkg::MEAN_W-1:0];
            end

            priority if (!count_ok) begin
                r_o_status <= ssk_pkg::ST_FEW;
            end else if (r_ovf) begin
                r_o_status <= ssk_pkg::ST_OVF;
            end else if (r_s2 == '0) begin
                r_o_status <= ssk_pkg::ST_ZERO;
            end else begin
                r_o_status <= ssk_pkg::ST_OK;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_skew_value = r_o_skew;
    assign o_mean_value = r_o_mean;
    assign o_status     = r_o_status;

    assign o_sts.div_done  = !r_dbusy;
    assign o_sts.mul_done  = mul_done;
    assign o_sts.idx_last  = (r_idx == (r_count - N_W'(1)));
    assign o_sts.bit_end   = (r_bit == '0);
    assign o_sts.skip_root = skip;
    assign o_sts.out_free  = !r_out_valid || !i_stall;

    // checks
    a_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_go |-> !mul_busy)
        else $error("multiplier started while busy");

    a_take_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_take |-> mul_done)
        else $error("multiplier result taken before done");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (!mul_busy && !r_dbusy))
        else $error("request accepted during computation");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> ((r_count == '0) && !r_ovf && (r_sum == '0)))
        else $error("list state not cleared after result");

endmodule

>>> rtl/sample_skewness.sv
`timescale 1ns / 1ps

// Population skewness of a list of signed samples. Each request carries one
// sample; the one with last set closes the list and produces one result with
// skew (16 fraction bits, saturated), mean (8 fraction bits) and a status
// (ok, fewer than three samples, zero deviation, samples dropped past the
// buffer depth). The input is not held off while samples load. The closing
// request then holds the input off while the result is worked out: the mean
// divider works out SAMPLE_BITS + clog2(MAX_SAMPLES+1) + 10 quotient bits, the
// deviation pass reads each stored sample and forms |d|^2 and |d|^3, and the
// root search forms S3^2 * n and S2^3 and then tests 23 bits, two products each;
// these two share the one shift-add multiplier, which retires one multiplier
// bit per cycle, and the deviation pass uses the single read port of the sample
// buffer. Deviation arithmetic is exact; the mean is rounded to nearest.
module sample_skewness #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ssk_pkg::SKEW_W-1:0]    o_skew_value,
    output logic [ssk_pkg::MEAN_W-1:0]    o_mean_value,
    output logic [ssk_pkg::STATUS_W-1:0]  o_status
);

    ssk_pkg::t_cmd cmd;
    ssk_pkg::t_sts sts;

    ssk_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_last),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    ssk_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_sample     (i_sample),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_skew_value (o_skew_value),
        .o_mean_value (o_mean_value),
        .o_status     (o_status)
    );

endmodule
